@@ rtl/core/sle_pkg.sv @@
package sle_pkg;

  localparam int DATA_W = 32;
  localparam int DEFAULT_CAPACITY = 16;

  localparam logic [3:0] MODE_INS_FRONT  = 4'd0;
  localparam logic [3:0] MODE_INS_REAR   = 4'd1;
  localparam logic [3:0] MODE_DEL_FRONT  = 4'd2;
  localparam logic [3:0] MODE_DEL_REAR   = 4'd3;
  localparam logic [3:0] MODE_INS_AT     = 4'd4;
  localparam logic [3:0] MODE_DEL_AT     = 4'd5;
  localparam logic [3:0] MODE_REVERSE    = 4'd6;
  localparam logic [3:0] MODE_UPDATE     = 4'd7;
  localparam logic [3:0] MODE_SEARCH     = 4'd8;
  localparam logic [3:0] MODE_SORTED_INS = 4'd9;
  localparam logic [3:0] MODE_DUMP       = 4'd10;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_BADPOS = 3'd2;
  localparam logic [2:0] ST_NOKEY  = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  typedef struct packed {
    logic [3:0]               mode;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] lookup_key;
    logic [7:0]               position;
  } req_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] result_value;
    logic [7:0]               found_position;
    logic                     last;
  } res_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_t;

endpackage

@@ rtl/core/sequence_list_engine.sv @@
// Ordered list engine holding up to CAPACITY signed 32-bit entries.
// A request on req (valid/ready) carries a mode, a value, a lookup key and a
// 1-based position; results leave on res (valid/ready) through an output
// register, and the last result of each request has last set. Dump gives one
// result per entry, every other mode gives exactly one result, and modes 11
// to 15 give none. Errors leave the list untouched and are reported in status.
// The engine works on one request at a time and req_ready is high only while
// it is idle; a finished result may still sit in the output register then.
// All work goes through one single-port-read, single-port-write entry memory
// with a registered read and one shared comparator, so the work for each
// request grows with the number of memory accesses: insert and delete shift
// the entries behind the index, update and search scan from the front up to
// the first hit or to the end, sorted insert scans for the first entry
// greater than the value and then shifts, reverse swaps pairs from both ends,
// and dump reads every entry.
// A stalled receiver holds the engine in its emit step until the output
// register frees up. Reset empties the list; the entry memory
// is not cleared because only entries below the count are ever read.
module sequence_list_engine #(
  parameter int CAPACITY = sle_pkg::DEFAULT_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sle_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output sle_pkg::res_t res
);
  import sle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SHIFT = 4'd1;
  localparam logic [3:0] S_FLUSH = 4'd2;
  localparam logic [3:0] S_PUT   = 4'd3;
  localparam logic [3:0] S_DREAD = 4'd4;
  localparam logic [3:0] S_DCAP  = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_DRD   = 4'd7;
  localparam logic [3:0] S_DEMIT = 4'd8;
  localparam logic [3:0] S_RVI   = 4'd9;
  localparam logic [3:0] S_RVJ   = 4'd10;
  localparam logic [3:0] S_RVW   = 4'd11;
  localparam logic [3:0] S_RVW2  = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  logic [3:0]        st, st_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [CW-1:0]     p, p_next;
  logic [CW-1:0]     q, q_next;
  logic [CW-1:0]     lim, lim_next;
  logic [CW-1:0]     idx, idx_next;
  logic [CW-1:0]     wa, wa_next;
  logic [CW-1:0]     sidx, sidx_next;
  logic              up, up_next;
  logic              wpend, wpend_next;
  logic              sv, sv_next;
  logic [3:0]        md, md_next;
  logic [DATA_W-1:0] val, val_next;
  logic [DATA_W-1:0] key, key_next;
  logic [DATA_W-1:0] tmp, tmp_next;
  logic [2:0]        rs_status, rs_status_next;
  logic [DATA_W-1:0] rs_val, rs_val_next;
  logic [7:0]        rs_pos, rs_pos_next;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;
  cmp_t              cmp;
  logic              hit;
  logic              push;
  logic              can_push;
  res_t              push_data;

  logic              full;
  logic              empty;
  logic [CMPW-1:0]   posx;
  logic [CMPW-1:0]   cntx;
  logic              ins_go;
  logic              del_go;
  logic [CW-1:0]     go_at;
  logic              dump_last;

  sle_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  sle_cmp u_cmp (
    .entry (rdata),
    .key   (key),
    .val   (val),
    .cmp   (cmp)
  );

  sle_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .can_push  (can_push),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign req_ready = (st == S_IDLE);
  assign full = (cnt == CW'(CAPACITY));
  assign empty = (cnt == '0);
  assign posx = CMPW'(req.position);
  assign cntx = CMPW'(cnt);
  assign hit = (md == MODE_SORTED_INS) ? cmp.gt : cmp.eq;
  assign dump_last = (p == cnt - CW'(1));

  always_comb begin
    st_next = st;
    cnt_next = cnt;
    p_next = p;
    q_next = q;
    lim_next = lim;
    idx_next = idx;
    wa_next = wa;
    sidx_next = sidx;
    up_next = up;
    wpend_next = 1'b0;
    sv_next = sv;
    md_next = md;
    val_next = val;
    key_next = key;
    tmp_next = tmp;
    rs_status_next = rs_status;
    rs_val_next = rs_val;
    rs_pos_next = rs_pos;
    we = wpend;
    waddr = wa[AW-1:0];
    wdata = rdata;
    raddr = (st == S_RVJ) ? q[AW-1:0] : p[AW-1:0];
    push = 1'b0;
    push_data = '0;
    ins_go = 1'b0;
    del_go = 1'b0;
    go_at = '0;

    unique case (st)
      S_IDLE: begin
        if (req_valid) begin
          md_next = req.mode;
          val_next = req.value;
          key_next = req.lookup_key;
          rs_status_next = ST_OK;
          rs_val_next = '0;
          rs_pos_next = '0;
          sv_next = 1'b0;
          p_next = '0;
          unique case (req.mode)
            MODE_INS_FRONT: begin
              if (full) begin
                rs_status_next = ST_FULL;
                st_next = S_EMIT;
              end else begin
                ins_go = 1'b1;
                go_at = '0;
              end
            end
            MODE_INS_REAR: begin
              if (full) begin
                rs_status_next = ST_FULL;
                st_next = S_EMIT;
              end else begin
                ins_go = 1'b1;
                go_at = cnt;
              end
            end
            MODE_INS_AT: begin
              if (posx == '0 || posx > cntx + CMPW'(1)) begin
                rs_status_next = ST_BADPOS;
                st_next = S_EMIT;
              end else if (full) begin
                rs_status_next = ST_FULL;
                st_next = S_EMIT;
              end else begin
                ins_go = 1'b1;
                go_at = CW'(posx - CMPW'(1));
              end
            end
            MODE_DEL_FRONT: begin
              if (empty) begin
                rs_status_next = ST_EMPTY;
                st_next = S_EMIT;
              end else begin
                del_go = 1'b1;
                go_at = '0;
              end
            end
            MODE_DEL_REAR: begin
              if (empty) begin
                rs_status_next = ST_EMPTY;
                st_next = S_EMIT;
              end else begin
                del_go = 1'b1;
                go_at = cnt - CW'(1);
              end
            end
            MODE_DEL_AT: begin
              if (posx == '0 || posx > cntx) begin
                rs_status_next = ST_BADPOS;
                st_next = S_EMIT;
              end else begin
                del_go = 1'b1;
                go_at = CW'(posx - CMPW'(1));
              end
            end
            MODE_REVERSE: begin
              if (empty) begin
                rs_status_next = ST_EMPTY;
                st_next = S_EMIT;
              end else begin
                q_next = cnt - CW'(1);
                st_next = (cnt < CW'(2)) ? S_EMIT : S_RVI;
              end
            end
            MODE_UPDATE, MODE_SEARCH: begin
              if (empty) begin
                rs_status_next = ST_EMPTY;
                st_next = S_EMIT;
              end else begin
                st_next = S_SCAN;
              end
            end
            MODE_SORTED_INS: begin
              if (full) begin
                rs_status_next = ST_FULL;
                st_next = S_EMIT;
              end else if (empty) begin
                ins_go = 1'b1;
                go_at = '0;
              end else begin
                st_next = S_SCAN;
              end
            end
            MODE_DUMP: begin
              if (empty) begin
                rs_status_next = ST_EMPTY;
                st_next = S_EMIT;
              end else begin
                st_next = S_DRD;
              end
            end
            default: begin
              st_next = S_IDLE;
            end
          endcase
          if (ins_go) begin
            idx_next = go_at;
            if (cnt > go_at) begin
              up_next = 1'b1;
              p_next = cnt - CW'(1);
              lim_next = go_at;
              st_next = S_SHIFT;
            end else begin
              st_next = S_PUT;
            end
          end
          if (del_go) begin
            idx_next = go_at;
            p_next = go_at;
            st_next = S_DREAD;
          end
        end
      end
      S_SHIFT: begin
        wpend_next = 1'b1;
        wa_next = up ? (p + CW'(1)) : (p - CW'(1));
        if (p == lim) begin
          st_next = S_FLUSH;
        end else begin
          p_next = up ? (p - CW'(1)) : (p + CW'(1));
        end
      end
      S_FLUSH: begin
        if (up) begin
          st_next = S_PUT;
        end else begin
          cnt_next = cnt - CW'(1);
          st_next = S_EMIT;
        end
      end
      S_PUT: begin
        we = 1'b1;
        waddr = idx[AW-1:0];
        wdata = val;
        cnt_next = cnt + CW'(1);
        st_next = S_EMIT;
      end
      S_DREAD: begin
        p_next = idx + CW'(1);
        st_next = S_DCAP;
      end
      S_DCAP: begin
        rs_val_next = rdata;
        if (idx + CW'(1) < cnt) begin
          up_next = 1'b0;
          lim_next = cnt - CW'(1);
          st_next = S_SHIFT;
        end else begin
          cnt_next = cnt - CW'(1);
          st_next = S_EMIT;
        end
      end
      S_SCAN: begin
        if (sv && hit) begin
          if (md == MODE_SEARCH) begin
            rs_pos_next = 8'(sidx) + 8'd1;
            st_next = S_EMIT;
          end else if (md == MODE_UPDATE) begin
            we = 1'b1;
            waddr = sidx[AW-1:0];
            wdata = val;
            st_next = S_EMIT;
          end else begin
            idx_next = sidx;
            up_next = 1'b1;
            p_next = cnt - CW'(1);
            lim_next = sidx;
            st_next = S_SHIFT;
          end
        end else if (sv && sidx == cnt - CW'(1)) begin
          if (md == MODE_SORTED_INS) begin
            idx_next = cnt;
            st_next = S_PUT;
          end else begin
            rs_status_next = ST_NOKEY;
            st_next = S_EMIT;
          end
        end else begin
          sv_next = 1'b1;
          sidx_next = p;
          p_next = p + CW'(1);
        end
      end
      S_DRD: begin
        st_next = S_DEMIT;
      end
      S_DEMIT: begin
        if (can_push) begin
          push = 1'b1;
          push_data.status = ST_OK;
          push_data.result_value = rdata;
          push_data.found_position = '0;
          push_data.last = dump_last;
          if (dump_last) begin
            st_next = S_IDLE;
          end else begin
            p_next = p + CW'(1);
            st_next = S_DRD;
          end
        end
      end
      S_RVI: begin
        st_next = S_RVJ;
      end
      S_RVJ: begin
        tmp_next = rdata;
        st_next = S_RVW;
      end
      S_RVW: begin
        we = 1'b1;
        waddr = p[AW-1:0];
        wdata = rdata;
        st_next = S_RVW2;
      end
      S_RVW2: begin
        we = 1'b1;
        waddr = q[AW-1:0];
        wdata = tmp;
        p_next = p + CW'(1);
        q_next = q - CW'(1);
        if ({1'b0, p} + (CW + 1)'(2) < {1'b0, q}) begin
          st_next = S_RVI;
        end else begin
          st_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_push) begin
          push = 1'b1;
          push_data.status = rs_status;
          push_data.result_value = rs_val;
          push_data.found_position = rs_pos;
          push_data.last = 1'b1;
          st_next = S_IDLE;
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      cnt <= '0;
      wpend <= 1'b0;
      sv <= 1'b0;
    end else begin
      st <= st_next;
      cnt <= cnt_next;
      wpend <= wpend_next;
      sv <= sv_next;
    end
  end

  always_ff @(posedge clk) begin
    p <= p_next;
    q <= q_next;
    lim <= lim_next;
    idx <= idx_next;
    wa <= wa_next;
    sidx <= sidx_next;
    up <= up_next;
    md <= md_next;
    val <= val_next;
    key <= key_next;
    tmp <= tmp_next;
    rs_status <= rs_status_next;
    rs_val <= rs_val_next;
    rs_pos <= rs_pos_next;
  end

endmodule

@@ rtl/core/sle_ram.sv @@
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/sle_cmp.sv @@
module sle_cmp (
  input  logic signed [sle_pkg::DATA_W-1:0] entry,
  input  logic signed [sle_pkg::DATA_W-1:0] key,
  input  logic signed [sle_pkg::DATA_W-1:0] val,
  output sle_pkg::cmp_t                     cmp
);
  import sle_pkg::*;

  always_comb begin
    cmp.eq = (entry == key);
    cmp.gt = (entry > val);
  end

endmodule

@@ rtl/core/sle_obuf.sv @@
module sle_obuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sle_pkg::res_t push_data,
  output logic          can_push,
  output logic          res_valid,
  input  logic          res_ready,
  output sle_pkg::res_t res
);
  import sle_pkg::*;

  assign can_push = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res <= push_data;
    end
  end

endmodule

@@ tb/sequence_list_engine_tb.sv @@
`timescale 1ns / 1ps

module sequence_list_engine_tb;
  import sle_pkg::*;

  localparam int ITEM_COUNT = 470;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 300;

  class list_scoreboard;
    logic signed [DATA_W-1:0] entries[$];
    res_t expected_results[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function void add_result(logic [2:0] status, logic [DATA_W-1:0] value,
                             logic [7:0] position, logic last);
      res_t r;
      r.status = status;
      r.result_value = value;
      r.found_position = position;
      r.last = last;
      expected_results.push_back(r);
    endfunction

    function int first_index(logic [DATA_W-1:0] key);
      int i;
      for (i = 0; i < entries.size(); i++) begin
        if (entries[i] == key) break;
      end
      return i;
    endfunction

    function void insert_entry(int idx, logic signed [DATA_W-1:0] v);
      if (idx >= entries.size()) entries.push_back(v);
      else entries.insert(idx, v);
    endfunction

    function void remove_entry(int idx);
      logic signed [DATA_W-1:0] t;
      t = entries[idx];
      entries.delete(idx);
      add_result(ST_OK, t, 8'd0, 1'b1);
    endfunction

    function void note_request(req_t r);
      int n;
      int idx;
      logic signed [DATA_W-1:0] t;
      n = entries.size();
      case (r.mode)
        MODE_INS_FRONT, MODE_INS_REAR, MODE_SORTED_INS: begin
          if (n >= DEFAULT_CAPACITY) begin
            add_result(ST_FULL, '0, 8'd0, 1'b1);
          end else begin
            if (r.mode == MODE_INS_FRONT) idx = 0;
            else if (r.mode == MODE_INS_REAR) idx = n;
            else begin
              idx = 0;
              while (idx < n && !(entries[idx] > $signed(r.value))) idx++;
            end
            insert_entry(idx, r.value);
            add_result(ST_OK, '0, 8'd0, 1'b1);
          end
        end
        MODE_INS_AT: begin
          if (int'(r.position) == 0 || int'(r.position) > n + 1)
            add_result(ST_BADPOS, '0, 8'd0, 1'b1);
          else if (n >= DEFAULT_CAPACITY)
            add_result(ST_FULL, '0, 8'd0, 1'b1);
          else begin
            insert_entry(int'(r.position) - 1, r.value);
            add_result(ST_OK, '0, 8'd0, 1'b1);
          end
        end
        MODE_DEL_FRONT, MODE_DEL_REAR: begin
          if (n == 0) add_result(ST_EMPTY, '0, 8'd0, 1'b1);
          else remove_entry((r.mode == MODE_DEL_FRONT) ? 0 : n - 1);
        end
        MODE_DEL_AT: begin
          if (int'(r.position) == 0 || int'(r.position) > n)
            add_result(ST_BADPOS, '0, 8'd0, 1'b1);
          else remove_entry(int'(r.position) - 1);
        end
        MODE_REVERSE: begin
          if (n == 0) begin
            add_result(ST_EMPTY, '0, 8'd0, 1'b1);
          end else begin
            for (idx = 0; idx < n / 2; idx++) begin
              t = entries[idx];
              entries[idx] = entries[n - 1 - idx];
              entries[n - 1 - idx] = t;
            end
            add_result(ST_OK, '0, 8'd0, 1'b1);
          end
        end
        MODE_UPDATE, MODE_SEARCH: begin
          if (n == 0) begin
            add_result(ST_EMPTY, '0, 8'd0, 1'b1);
          end else begin
            idx = first_index(r.lookup_key);
            if (idx >= n) add_result(ST_NOKEY, '0, 8'd0, 1'b1);
            else if (r.mode == MODE_UPDATE) begin
              entries[idx] = r.value;
              add_result(ST_OK, '0, 8'd0, 1'b1);
            end else add_result(ST_OK, '0, 8'(idx + 1), 1'b1);
          end
        end
        MODE_DUMP: begin
          if (n == 0) add_result(ST_EMPTY, '0, 8'd0, 1'b1);
          else begin
            for (idx = 0; idx < n; idx++)
              add_result(ST_OK, entries[idx], 8'd0, idx == n - 1);
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s expected %h got %h", $time, field, want, got);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0d value %h position %0d last %0b",
                 $time, got.status, got.result_value, got.found_position, got.last);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report("status", 32'(want.status), 32'(got.status));
      if (got.result_value !== want.result_value)
        report("result_value", want.result_value, got.result_value);
      if (got.found_position !== want.found_position)
        report("found_position", 32'(want.found_position), 32'(got.found_position));
      if (got.last !== want.last) report("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic res_valid;
  logic res_ready;
  res_t res;

  list_scoreboard sb;
  bit steady = 1'b0;
  bit hold_results = 1'b0;
  int unsigned cycle_count = 0;

  sequence_list_engine #(.CAPACITY(DEFAULT_CAPACITY)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Outputs and inputs change only at the rising edge, so sampling at the
  // falling edge sees exactly what the next rising edge will take.
  always @(negedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_result(res);
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 96) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(3))
      0: return DATA_W'(int'($urandom_range(16)) - 8);
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic req_t make_request(logic [3:0] mode, logic [DATA_W-1:0] value,
                                        logic [DATA_W-1:0] key, logic [7:0] position);
    req_t r;
    r.mode = mode;
    r.value = value;
    r.lookup_key = key;
    r.position = position;
    return r;
  endfunction

  function automatic req_t random_request(bit filling);
    req_t r;
    int n;
    int p;
    n = sb.entries.size();
    p = $urandom_range(99);
    if (p < 3) begin
      r.mode = 4'($urandom_range(15, 11));
    end else if (p < 60) begin
      if (filling) begin
        case ($urandom_range(3))
          0: r.mode = MODE_INS_FRONT;
          1: r.mode = MODE_INS_REAR;
          2: r.mode = MODE_INS_AT;
          default: r.mode = MODE_SORTED_INS;
        endcase
      end else begin
        case ($urandom_range(2))
          0: r.mode = MODE_DEL_FRONT;
          1: r.mode = MODE_DEL_REAR;
          default: r.mode = MODE_DEL_AT;
        endcase
      end
    end else begin
      r.mode = 4'($urandom_range(10));
    end
    r.value = random_value();
    if (n > 0 && $urandom_range(3) != 0) r.lookup_key = sb.entries[$urandom_range(n - 1)];
    else r.lookup_key = random_value();
    if ($urandom_range(9) == 0) r.position = 8'($urandom_range(255));
    else r.position = 8'($urandom_range(n + 1));
    return r;
  endfunction

  task automatic drive(input req_t r);
    int gap;
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int stall;
    res_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_results) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        stall = steady ? 0 : pick_gap();
        if (stall > 0) begin
          res_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        res_ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    req_t directed[$];
    req_t r;
    int sent;
    int iter;
    int phase_left;
    bit filling;
    sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(make_request(MODE_DUMP, 32'h1, 32'h1, 8'd1));
    directed.push_back(make_request(MODE_DEL_FRONT, 32'h0, 32'h0, 8'd0));
    directed.push_back(make_request(MODE_DEL_REAR, 32'h0, 32'h0, 8'd0));
    directed.push_back(make_request(MODE_REVERSE, 32'h0, 32'h0, 8'd0));
    directed.push_back(make_request(MODE_UPDATE, 32'h5, 32'h0, 8'd0));
    directed.push_back(make_request(MODE_SEARCH, 32'h0, 32'h0, 8'd0));
    directed.push_back(make_request(MODE_DEL_AT, 32'h0, 32'h0, 8'd1));
    directed.push_back(make_request(MODE_DEL_AT, 32'h0, 32'h0, 8'd0));
    directed.push_back(make_request(MODE_INS_AT, 32'h7, 32'h0, 8'd0));
    directed.push_back(make_request(MODE_INS_AT, 32'h7, 32'h0, 8'd2));
    directed.push_back(make_request(MODE_INS_AT, 32'h8000_0000, 32'h0, 8'd1));
    directed.push_back(make_request(MODE_INS_FRONT, 32'h7fff_ffff, 32'h0, 8'd0));
    directed.push_back(make_request(MODE_INS_REAR, 32'hffff_ffff, 32'h0, 8'd0));
    directed.push_back(make_request(MODE_SORTED_INS, 32'h0, 32'h0, 8'd0));
    directed.push_back(make_request(MODE_SEARCH, 32'h0, 32'h8000_0000, 8'd0));
    directed.push_back(make_request(MODE_SEARCH, 32'h0, 32'h0000_3039, 8'd0));
    directed.push_back(make_request(MODE_UPDATE, 32'h55aa_55aa, 32'hffff_ffff, 8'd0));
    directed.push_back(make_request(MODE_REVERSE, 32'h0, 32'h0, 8'd0));
    directed.push_back(make_request(MODE_DUMP, 32'h0, 32'h0, 8'd0));
    directed.push_back(make_request(MODE_DEL_AT, 32'h0, 32'h0, 8'd255));
    directed.push_back(make_request(MODE_INS_AT, 32'h1234_5678, 32'h0, 8'd255));
    directed.push_back(make_request(4'd15, 32'hffff_ffff, 32'hffff_ffff, 8'd255));
    directed.push_back(make_request(MODE_DEL_AT, 32'h0, 32'h0, 8'd2));
    directed.push_back(make_request(4'd11, 32'h0, 32'h0, 8'd1));
    directed.push_back(make_request(MODE_INS_AT, 32'hdead_beef, 32'h0, 8'd4));
    directed.push_back(make_request(MODE_DUMP, 32'h0, 32'h0, 8'd0));
    foreach (directed[i]) drive(directed[i]);

    sent = 0;
    iter = 0;
    phase_left = 0;
    filling = 1'b1;
    while (sent < ITEM_COUNT) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 50);
        filling = !filling;
        steady = ($urandom_range(3) == 0);
      end
      phase_left--;
      if (iter == 150) hold_results = 1'b1;
      if (iter == 300) begin
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0) @(posedge clk);
      end
      r = random_request(filling);
      drive(r);
      if (r.mode <= MODE_DUMP) sent++;
      iter++;
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
